// ===== rtl/bb3_pkg.sv =====
package bb3_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_t;

  localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST = 11'd480;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  localparam int CH_W       = 8;
  localparam int SUM_W      = 12;
  localparam int PROD_W     = 24;
  localparam int DIV9_SHIFT = 15;
  // floor(s / 9) == (s * 3641) >> 15 for all s < 2296
  localparam logic [SUM_W-1:0] DIV9_MUL = 12'd3641;

  localparam int OUT_FIFO_DEPTH = 8;
  localparam int OUT_PTR_W      = 3;
  localparam int OUT_CNT_W      = 4;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } pixel_t;

  typedef struct packed {
    pixel_t upper;
    pixel_t middle;
  } line_word_t;

  typedef struct packed {
    logic            kind;
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
    logic            frame_end;
  } out_item_t;

  typedef struct packed {
    logic has_out;
    logic row_top;
    logic row_bot;
    logic col_left;
    logic col_right;
    logic last;
  } win_ctl_t;

endpackage

// ===== rtl/bb3_line_store.sv =====
module bb3_line_store #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic                clk,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output bb3_pkg::line_word_t rd_data,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  bb3_pkg::line_word_t wr_data
);

  bb3_pkg::line_word_t mem [DEPTH];
  bb3_pkg::line_word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/bb3_window.sv =====
module bb3_window (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               shift_en,
  input  bb3_pkg::pixel_t    above,
  input  bb3_pkg::pixel_t    mid,
  input  bb3_pkg::pixel_t    pix,
  input  bb3_pkg::win_ctl_t  ctl_in,
  output logic               push,
  output bb3_pkg::out_item_t push_item,
  output logic [1:0]         pend
);

  bb3_pkg::pixel_t   win_r [9];
  logic              s2_vld_r;
  bb3_pkg::win_ctl_t s2_ctl_r;
  logic              s3_vld_r;
  bb3_pkg::win_ctl_t s3_ctl_r;
  logic [bb3_pkg::SUM_W-1:0] s3_sum_r [3];
  logic [bb3_pkg::SUM_W-1:0] sum_nxt [3];
  logic [bb3_pkg::PROD_W-1:0] prod [3];
  logic [2:0] rok;
  logic [2:0] cok;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r*3]   <= win_r[r*3+1];
        win_r[r*3+1] <= win_r[r*3+2];
      end
      win_r[2] <= above;
      win_r[5] <= mid;
      win_r[8] <= pix;
    end
  end

  always_comb begin
    rok = {s2_ctl_r.row_bot, 1'b1, s2_ctl_r.row_top};
    cok = {s2_ctl_r.col_right, 1'b1, s2_ctl_r.col_left};
    for (int k = 0; k < 3; k++) begin
      sum_nxt[k] = '0;
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (rok[r] && cok[c]) begin
          sum_nxt[0] = sum_nxt[0] + bb3_pkg::SUM_W'(win_r[r*3+c].r);
          sum_nxt[1] = sum_nxt[1] + bb3_pkg::SUM_W'(win_r[r*3+c].g);
          sum_nxt[2] = sum_nxt[2] + bb3_pkg::SUM_W'(win_r[r*3+c].b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= shift_en && ctl_in.has_out;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_ctl_r <= ctl_in;
    s3_ctl_r <= s2_ctl_r;
    for (int k = 0; k < 3; k++) begin
      s3_sum_r[k] <= sum_nxt[k];
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod[k] = bb3_pkg::PROD_W'(s3_sum_r[k]) * bb3_pkg::PROD_W'(bb3_pkg::DIV9_MUL);
    end
  end

  assign push                = s3_vld_r;
  assign push_item.red_out   = prod[0][bb3_pkg::DIV9_SHIFT +: bb3_pkg::CH_W];
  assign push_item.green_out = prod[1][bb3_pkg::DIV9_SHIFT +: bb3_pkg::CH_W];
  assign push_item.blue_out  = prod[2][bb3_pkg::DIV9_SHIFT +: bb3_pkg::CH_W];
  assign push_item.frame_end = s3_ctl_r.last;
  assign pend                = {s2_vld_r, s3_vld_r};

endmodule

// ===== rtl/bb3_out_fifo.sv =====
module bb3_out_fifo (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  input  bb3_pkg::out_item_t                push_item,
  input  logic                              pop_ready,
  output logic                              out_valid,
  output bb3_pkg::out_item_t                out_item,
  output logic [bb3_pkg::OUT_CNT_W-1:0]     count
);

  bb3_pkg::out_item_t mem_r [bb3_pkg::OUT_FIFO_DEPTH];
  logic [bb3_pkg::OUT_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [bb3_pkg::OUT_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [bb3_pkg::OUT_CNT_W-1:0] cnt_r, cnt_nxt;
  logic pop;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && pop_ready;
  assign out_item  = mem_r[rd_ptr_r];
  assign count     = cnt_r;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + bb3_pkg::OUT_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + bb3_pkg::OUT_PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + bb3_pkg::OUT_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - bb3_pkg::OUT_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/box_blur_3x3_rgb_core.sv =====
// 3x3 box blur, RGB888, raster order. One transaction per clock while in_ready
// is high. A result goes to the output queue and is offered once the transaction
// completing its window has passed line store read, window shift and sum, and
// divide by nine. in_ready drops while queued plus in-flight results reach 8.
// Synchronous active-low reset clears positions, pipeline and queue; sizes go to
// 640x480. Line store contents are not cleared: edge masks hide stale entries.
module box_blur_3x3_rgb_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  bb3_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output bb3_pkg::out_item_t                 out_data,
  input  logic                               cfg_wr_en,
  input  logic [bb3_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bb3_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 2);

  function automatic logic [WW-1:0] clamp_w(logic [bb3_pkg::CFG_DATA_W-1:0] v);
    logic [WW-1:0] res;
    if (v == '0) begin
      res = WW'(1);
    end else if (32'(v) > MAX_WIDTH) begin
      res = WW'(MAX_WIDTH);
    end else begin
      res = WW'(v);
    end
    return res;
  endfunction

  function automatic logic [HW-1:0] clamp_h(logic [bb3_pkg::CFG_DATA_W-1:0] v);
    logic [HW-1:0] res;
    if (v == '0) begin
      res = HW'(1);
    end else if (32'(v) > MAX_HEIGHT) begin
      res = HW'(MAX_HEIGHT);
    end else begin
      res = HW'(v);
    end
    return res;
  endfunction

  logic [WW-1:0] w_r, w_nxt;
  logic [HW-1:0] h_r, h_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;

  logic          acc, adv, row_lt_h, col_wrap, out_ok;
  logic [CW-1:0] ix, ox;
  logic [RW-1:0] oy, h_ext;
  logic [WW-1:0] ix_p1;
  bb3_pkg::pixel_t   pix;
  bb3_pkg::win_ctl_t ctl;

  logic              s1_vld_r;
  logic [CW-1:0]     s1_ix_r;
  bb3_pkg::pixel_t   s1_pix_r;
  bb3_pkg::win_ctl_t s1_ctl_r;
  logic              fwd_r;
  bb3_pkg::pixel_t   fwd_up_r;
  bb3_pkg::pixel_t   fwd_mid_r;
  bb3_pkg::pixel_t   above_e, mid_e;
  bb3_pkg::line_word_t rd_word, wr_word;

  logic [1:0]                    pend;
  logic                          push;
  bb3_pkg::out_item_t            push_item;
  logic [bb3_pkg::OUT_CNT_W-1:0] q_cnt;
  logic [bb3_pkg::OUT_CNT_W-1:0] busy;

  // credit check: queue entries plus results still in the pipe
  assign busy = q_cnt + bb3_pkg::OUT_CNT_W'(pend[0]) + bb3_pkg::OUT_CNT_W'(pend[1])
              + bb3_pkg::OUT_CNT_W'(s1_vld_r && s1_ctl_r.has_out);
  assign in_ready = (32'(busy) < bb3_pkg::OUT_FIFO_DEPTH);
  assign acc      = in_valid && in_ready;

  assign h_ext    = RW'(h_r);
  assign row_lt_h = row_r < h_ext;
  assign adv      = acc && !(row_lt_h && (in_data.kind == bb3_pkg::KIND_FLUSH));

  always_comb begin
    pix = '0;
    if (row_lt_h) begin
      pix.r = in_data.red_in;
      pix.g = in_data.green_in;
      pix.b = in_data.blue_in;
    end
  end

  always_comb begin
    ix       = (WW'(col_r) >= w_r) ? '0 : col_r;
    ix_p1    = WW'(ix) + WW'(1);
    col_wrap = ix_p1 >= w_r;
    if (ix != '0) begin
      out_ok = row_r != '0;
      ox     = ix - CW'(1);
      oy     = row_r - RW'(1);
    end else begin
      out_ok = row_r >= RW'(2);
      ox     = CW'(w_r - WW'(1));
      oy     = row_r - RW'(2);
    end
    ctl.has_out   = out_ok && (oy < h_ext);
    ctl.row_top   = oy != '0;
    ctl.row_bot   = (oy + RW'(1)) < h_ext;
    ctl.col_left  = ox != '0;
    ctl.col_right = (WW'(ox) + WW'(1)) < w_r;
    ctl.last      = (oy == h_ext - RW'(1)) && (WW'(ox) == w_r - WW'(1));
  end

  always_comb begin
    w_nxt   = w_r;
    h_nxt   = h_r;
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_wr_en) begin
      case (bb3_pkg::cfg_idx_t'(cfg_index))
        bb3_pkg::CFG_FRAME_WIDTH:  w_nxt = clamp_w(cfg_wdata);
        bb3_pkg::CFG_FRAME_HEIGHT: h_nxt = clamp_h(cfg_wdata);
        default: ;
      endcase
      col_nxt = '0;
      row_nxt = '0;
    end else if (adv) begin
      if (ctl.has_out && ctl.last) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_wrap) begin
        col_nxt = '0;
        row_nxt = row_r + RW'(1);
      end else begin
        col_nxt = CW'(ix_p1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r      <= clamp_w(bb3_pkg::FRAME_WIDTH_RST);
      h_r      <= clamp_h(bb3_pkg::FRAME_HEIGHT_RST);
      col_r    <= '0;
      row_r    <= '0;
      s1_vld_r <= 1'b0;
    end else begin
      w_r      <= w_nxt;
      h_r      <= h_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      s1_vld_r <= adv;
    end
  end

  // read-during-write on the same column (width one): forward the write
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ix_r   <= ix;
      s1_pix_r  <= pix;
      s1_ctl_r  <= ctl;
      fwd_r     <= s1_vld_r && (s1_ix_r == ix);
      fwd_up_r  <= mid_e;
      fwd_mid_r <= s1_pix_r;
    end
  end

  assign above_e = fwd_r ? fwd_up_r  : rd_word.upper;
  assign mid_e   = fwd_r ? fwd_mid_r : rd_word.middle;

  assign wr_word.upper  = mid_e;
  assign wr_word.middle = s1_pix_r;

  bb3_line_store #(
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (CW)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (adv),
    .rd_addr (ix),
    .rd_data (rd_word),
    .wr_en   (s1_vld_r),
    .wr_addr (s1_ix_r),
    .wr_data (wr_word)
  );

  bb3_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .shift_en  (s1_vld_r),
    .above     (above_e),
    .mid       (mid_e),
    .pix       (s1_pix_r),
    .ctl_in    (s1_ctl_r),
    .push      (push),
    .push_item (push_item),
    .pend      (pend)
  );

  bb3_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop_ready (out_ready),
    .out_valid (out_valid),
    .out_item  (out_data),
    .count     (q_cnt)
  );

endmodule

// ===== test/box_blur_3x3_rgb_core_tb.sv =====
`timescale 1ns / 100ps

module box_blur_3x3_rgb_core_tb;
  import bb3_pkg::*;

  localparam int MAX_DIM      = 1024;
  localparam int RANDOM_ITEMS = 350;
  localparam int SETTLE       = 16;
  localparam int HOLD_CYCLES  = 300;
  localparam int LIMIT        = 2000000;

  function automatic int usable_dim(int v);
    if (v < 1) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  class blur_tracker;
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    pixel_t upper_line[MAX_DIM];
    pixel_t middle_line[MAX_DIM];
    pixel_t win[9];
    int col;
    int row;
    out_item_t expected_pixels[$];
    int errors;
    int results_checked;
    int frames_seen;

    function new();
      int i;
      width_reg  = FRAME_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
      for (i = 0; i < MAX_DIM; i++) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      for (i = 0; i < 9; i++) win[i] = '0;
      col = 0;
      row = 0;
      errors = 0;
      results_checked = 0;
      frames_seen = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
      if (idx == CFG_FRAME_WIDTH) width_reg = v;
      else height_reg = v;
      col = 0;
      row = 0;
    endfunction

    // one accepted input transaction: ignore an in-frame flush, else shift the window, maybe queue a blurred pixel
    function void note_input(in_item_t it);
      int w, h, ix, iy, ox, oy, r, c, sr, sg, sbl;
      pixel_t px, above, mid;
      bit row_ok[3];
      bit col_ok[3];
      out_item_t e;
      w = usable_dim(width_reg);
      h = usable_dim(height_reg);
      px = '0;
      if (row < h) begin
        if (it.kind == KIND_FLUSH) return;
        px.r = it.red_in;
        px.g = it.green_in;
        px.b = it.blue_in;
      end
      ix = col;
      iy = row;
      if (ix >= w) ix = 0;
      above = upper_line[ix];
      mid = middle_line[ix];
      upper_line[ix] = mid;
      middle_line[ix] = px;
      for (r = 0; r < 3; r++) begin
        win[r*3]   = win[r*3+1];
        win[r*3+1] = win[r*3+2];
      end
      win[2] = above;
      win[5] = mid;
      win[8] = px;
      if (ix + 1 >= w) begin
        col = 0;
        row = iy + 1;
      end else begin
        col = ix + 1;
      end
      if (ix >= 1) begin
        if (iy < 1) return;
        ox = ix - 1;
        oy = iy - 1;
      end else begin
        if (iy < 2) return;
        ox = w - 1;
        oy = iy - 2;
      end
      if (oy >= h) return;
      row_ok[0] = (oy >= 1);
      row_ok[1] = 1'b1;
      row_ok[2] = (oy + 1 < h);
      col_ok[0] = (ox >= 1);
      col_ok[1] = 1'b1;
      col_ok[2] = (ox + 1 < w);
      sr = 0;
      sg = 0;
      sbl = 0;
      for (r = 0; r < 3; r++) begin
        for (c = 0; c < 3; c++) begin
          if (row_ok[r] && col_ok[c]) begin
            sr += win[r*3+c].r;
            sg += win[r*3+c].g;
            sbl += win[r*3+c].b;
          end
        end
      end
      e.red_out   = CH_W'(sr / 9);
      e.green_out = CH_W'(sg / 9);
      e.blue_out  = CH_W'(sbl / 9);
      e.frame_end = (oy == h - 1) && (ox == w - 1);
      if (e.frame_end) begin
        col = 0;
        row = 0;
        frames_seen++;
      end
      expected_pixels.insert(expected_pixels.size(), e);
    endfunction

    function void check_field(string name, int want, int got);
      if (want != got) begin
        errors++;
        $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (expected_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected result r=%0d g=%0d b=%0d end=%0d", $time,
                 got.red_out, got.green_out, got.blue_out, got.frame_end);
        return;
      end
      e = expected_pixels.pop_front();
      check_field("red_out", e.red_out, got.red_out);
      check_field("green_out", e.green_out, got.green_out);
      check_field("blue_out", e.blue_out, got.blue_out);
      check_field("frame_end", e.frame_end, got.frame_end);
      results_checked++;
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  blur_tracker tracker;
  bit  steady = 1'b0;
  bit  hold_request = 1'b0;
  int  cycles = 0;
  int  inputs_accepted = 0;
  int  fed_items = 0;
  int  reg_writes = 0;

  box_blur_3x3_rgb_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time,
               tracker.expected_pixels.size());
      $display("box_blur_3x3_rgb_core verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tracker.check_result(out_data);
  end

  initial begin : receiver
    int n;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else if (steady) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
        if ($urandom_range(15) == 0) n = $urandom_range(10, 40);
        else n = $urandom_range(0, 3);
        if (n > 0) begin
          out_ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
    end
  end

  function automatic int pick_gap();
    if (steady) return 0;
    if ($urandom_range(15) == 0) return $urandom_range(8, 40);
    if ($urandom_range(1) == 0) return 0;
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [CH_W-1:0] rand_channel();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return CH_W'($urandom_range(255));
    endcase
  endfunction

  function automatic in_item_t pixel_of(int r, int g, int b);
    in_item_t it;
    it.kind     = KIND_PIXEL;
    it.red_in   = CH_W'(r);
    it.green_in = CH_W'(g);
    it.blue_in  = CH_W'(b);
    return it;
  endfunction

  function automatic in_item_t rand_pixel();
    return pixel_of(rand_channel(), rand_channel(), rand_channel());
  endfunction

  function automatic in_item_t rand_flush();
    in_item_t it;
    it = pixel_of($urandom_range(255), $urandom_range(255), $urandom_range(255));
    it.kind = KIND_FLUSH;
    return it;
  endfunction

  // called at a rising edge; returns at the edge that accepts the transaction
  task automatic send(in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    tracker.note_input(it);
    inputs_accepted++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (tracker.expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_size(int wv, int hv);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_FRAME_WIDTH;
    cfg_wdata <= CFG_DATA_W'(wv);
    tracker.write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(wv));
    @(posedge clk);
    cfg_index <= CFG_FRAME_HEIGHT;
    cfg_wdata <= CFG_DATA_W'(hv);
    tracker.write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(hv));
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    reg_writes += 2;
    @(posedge clk);
  endtask

  // full frame then width+1 drain transactions; noisy adds ignored flushes and
  // pixels in the drain
  task automatic send_frame(int w, int h, bit noisy);
    int i;
    for (i = 0; i < w * h; i++) begin
      if (noisy && $urandom_range(9) == 0) send(rand_flush());
      send(rand_pixel());
      fed_items++;
    end
    for (i = 0; i <= w; i++) begin
      if (noisy && $urandom_range(3) == 0) send(rand_pixel());
      else send(rand_flush());
      fed_items++;
    end
    if (noisy && $urandom_range(5) == 0) send(rand_flush());
  endtask

  initial begin : stimulus
    int i, w, h, wr, hr, f, nf, cut;
    tracker = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // a few pixels at the reset size, abandoned by the first write
    for (i = 0; i < 3; i++) send(rand_pixel());

    set_size(3, 2);
    send(pixel_of(255, 255, 255));
    send(pixel_of(0, 0, 0));
    send(pixel_of(255, 0, 128));
    send(rand_flush());
    send(pixel_of(1, 254, 127));
    send(pixel_of(255, 255, 255));
    send(pixel_of(0, 255, 0));
    send(rand_flush());
    send(pixel_of(17, 34, 51));
    send(rand_flush());
    send(rand_flush());

    set_size(0, 0);
    send(pixel_of(255, 255, 255));
    send(rand_flush());
    send(rand_flush());

    set_size(2, 1);
    send(pixel_of(255, 128, 0));
    send(pixel_of(255, 255, 255));
    send(rand_flush());
    send(rand_flush());
    send(rand_flush());
    send(rand_flush());

    // size extremes
    set_size(40, 1);
    send_frame(40, 1, 1'b0);
    set_size(2047, 2047);
    for (i = 0; i < 20; i++) send(rand_pixel());
    set_size(1, 40);
    send_frame(1, 40, 1'b1);

    // receiver stalls for a long stretch while the sender keeps pushing
    set_size(8, 8);
    steady = 1'b1;
    hold_request = 1'b1;
    send_frame(8, 8, 1'b0);
    steady = 1'b0;

    fed_items = 0;
    while (fed_items < RANDOM_ITEMS) begin
      case ($urandom_range(9))
        0: wr = 0;
        1: wr = $urandom_range(13, 40);
        default: wr = $urandom_range(1, 12);
      endcase
      hr = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
      set_size(wr, hr);
      steady = ($urandom_range(4) == 0);
      w = usable_dim(wr);
      h = usable_dim(hr);
      nf = $urandom_range(1, 3);
      for (f = 0; f < nf; f++) begin
        if ($urandom_range(7) == 0) begin
          cut = $urandom_range(0, w * h - 1);
          for (i = 0; i < cut; i++) begin
            send(rand_pixel());
            fed_items++;
          end
          f = nf;
        end else begin
          send_frame(w, h, $urandom_range(2) != 0);
        end
      end
      steady = 1'b0;
    end

    wait_idle();
    $display("%0d input transactions, %0d blurred pixels checked, %0d frames completed",
             inputs_accepted, tracker.results_checked, tracker.frames_seen);
    $display("%0d register writes; frames from 1x1 up to 40 wide or 40 tall, clamped sizes",
             reg_writes);
    if (tracker.errors == 0) begin
      $display("box_blur_3x3_rgb_core verification clean");
    end else begin
      $display("box_blur_3x3_rgb_core verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bb3_pkg.sv
rtl/bb3_line_store.sv
rtl/bb3_window.sv
rtl/bb3_out_fifo.sv
rtl/box_blur_3x3_rgb_core.sv
test/box_blur_3x3_rgb_core_tb.sv
